// ===== src/glmf_pkg.sv =====
// Shared types and constants for the grid local maximum finder.
package glmf_pkg;

    localparam int ROW_BITS      = 16;
    localparam int COLS_CFG_BITS = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 2'd1;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Decision request from the raster scanner to the peak stage
    typedef struct packed {
        logic                decide;
        logic                row_par;
        logic                has_up;
        logic                has_down;
        logic                has_left;
        logic                has_right;
        logic                last;
        logic [ROW_BITS-1:0] row;
    } glmf_ctl_t;

endpackage

// ===== src/glmf_line_buf.sv =====
// One line store: single write port, two registered read ports.
module glmf_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 16
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_BITS-1:0]        wr_addr,
    input  logic signed [DATA_BITS-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_BITS-1:0]        rd_addr_a,
    input  logic [ADDR_BITS-1:0]        rd_addr_b,
    output logic signed [DATA_BITS-1:0] rd_data_a,
    output logic signed [DATA_BITS-1:0] rd_data_b
);

    logic signed [DATA_BITS-1:0] store_reg [DEPTH];
    logic signed [DATA_BITS-1:0] rd_a_reg;
    logic signed [DATA_BITS-1:0] rd_b_reg;

    // Reads return the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= store_reg[rd_addr_a];
            rd_b_reg <= store_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== src/glmf_scan.sv =====
// Raster position, frame control and grid size registers.
module glmf_scan #(
    parameter int MAX_COLS = 1024,
    parameter int COL_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [glmf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [glmf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                step,
    input  logic                                command,
    output glmf_pkg::glmf_ctl_t                 ctl,
    output logic [COL_BITS-1:0]                 col,
    output logic                                wr_en,
    output logic                                wr_par
);

    import glmf_pkg::*;

    localparam logic [COLS_CFG_BITS-1:0] COL_LIMIT =
        (MAX_COLS > 2047) ? 11'd2047 : COLS_CFG_BITS'(MAX_COLS);

    logic [ROW_BITS-1:0]      in_row_reg, in_row_next;
    logic [COL_BITS-1:0]      in_col_reg, in_col_next;
    logic                     full_reg, full_next;
    logic [ROW_BITS-1:0]      rows_last_reg, rows_last_next;
    logic [COL_BITS-1:0]      cols_last_reg, cols_last_next;

    logic                     at_last_col;
    logic                     at_last_row;
    logic                     pix_ok;
    logic                     drn_ok;
    logic [ROW_BITS-1:0]      dec_row;
    logic [ROW_BITS-1:0]      cfg_rows;
    logic [COLS_CFG_BITS-1:0] cfg_cols;
    logic [COLS_CFG_BITS-1:0] cols_eff;

    assign at_last_col = (in_col_reg == cols_last_reg);
    assign at_last_row = (in_row_reg == rows_last_reg);
    assign pix_ok      = (command == CMD_PIXEL) && !full_reg;
    assign drn_ok      = (command == CMD_DRAIN) && full_reg;

    // While pixels stream in, row r decides row r-1; once full, drains decide the last row
    assign dec_row = full_reg ? rows_last_reg : (in_row_reg - ROW_BITS'(1));

    always_comb
    begin
        ctl           = '0;
        ctl.decide    = (pix_ok && (in_row_reg != '0)) || drn_ok;
        ctl.row       = dec_row;
        ctl.row_par   = dec_row[0];
        ctl.has_up    = (dec_row != '0);
        ctl.has_down  = !full_reg;
        ctl.has_left  = (in_col_reg != '0);
        ctl.has_right = !at_last_col;
        ctl.last      = full_reg && at_last_col;
    end

    assign col    = in_col_reg;
    assign wr_en  = step && pix_ok;
    assign wr_par = in_row_reg[0];

    assign cfg_rows = cfg_data[ROW_BITS-1:0];
    assign cfg_cols = cfg_data[COLS_CFG_BITS-1:0];

    always_comb
    begin
        if (cfg_cols == '0)
        begin
            cols_eff = COLS_CFG_BITS'(1);
        end
        else if (cfg_cols > COL_LIMIT)
        begin
            cols_eff = COL_LIMIT;
        end
        else
        begin
            cols_eff = cfg_cols;
        end
    end

    always_comb
    begin
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        full_next      = full_reg;
        rows_last_next = rows_last_reg;
        cols_last_next = cols_last_reg;
        if (cfg_wr && ((cfg_index == CFG_GRID_ROWS) || (cfg_index == CFG_GRID_COLS)))
        begin
            in_row_next = '0;
            in_col_next = '0;
            full_next   = 1'b0;
            case (cfg_index)
                CFG_GRID_ROWS:
                begin
                    rows_last_next = (cfg_rows == '0) ? '0 : (cfg_rows - ROW_BITS'(1));
                end
                CFG_GRID_COLS:
                begin
                    cols_last_next = COL_BITS'(cols_eff - COLS_CFG_BITS'(1));
                end
                default:
                begin
                    rows_last_next = rows_last_reg;
                end
            endcase
        end
        else if (step && pix_ok)
        begin
            if (at_last_col)
            begin
                in_col_next = '0;
                if (at_last_row)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + ROW_BITS'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_BITS'(1);
            end
        end
        else if (step && drn_ok)
        begin
            if (at_last_col)
            begin
                in_row_next = '0;
                in_col_next = '0;
                full_next   = 1'b0;
            end
            else
            begin
                in_col_next = in_col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            full_reg      <= 1'b0;
            rows_last_reg <= '0;
            cols_last_reg <= '0;
        end
        else
        begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            full_reg      <= full_next;
            rows_last_reg <= rows_last_next;
            cols_last_reg <= cols_last_next;
        end
    end

endmodule

// ===== src/glmf_peak.sv =====
// Neighbour compare stage and result register with output handshake.
module glmf_peak #(
    parameter int COL_BITS   = 10,
    parameter int VALUE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              enter,
    input  glmf_pkg::glmf_ctl_t               ctl,
    input  logic [COL_BITS-1:0]               col,
    input  logic signed [VALUE_BITS-1:0]      down,
    input  logic signed [VALUE_BITS-1:0]      buf0_a,
    input  logic signed [VALUE_BITS-1:0]      buf0_b,
    input  logic signed [VALUE_BITS-1:0]      buf1_a,
    input  logic signed [VALUE_BITS-1:0]      buf1_b,
    output logic                              take,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [glmf_pkg::ROW_BITS-1:0]     cell_row,
    output logic [COL_BITS-1:0]               cell_col,
    output logic                              is_peak,
    output logic                              frame_last
);

    import glmf_pkg::*;

    logic                         s1_valid_reg, s1_valid_next;
    logic                         out_valid_reg, out_valid_next;
    glmf_ctl_t                    s1_ctl_reg, s1_ctl_next;
    logic [COL_BITS-1:0]          s1_col_reg, s1_col_next;
    logic signed [VALUE_BITS-1:0] s1_down_reg, s1_down_next;
    logic signed [VALUE_BITS-1:0] left_reg, left_next;
    logic [ROW_BITS-1:0]          row_reg, row_next;
    logic [COL_BITS-1:0]          col_reg, col_next;
    logic                         peak_reg, peak_next;
    logic                         last_reg, last_next;

    logic                         s1_move;
    logic signed [VALUE_BITS-1:0] centre;
    logic signed [VALUE_BITS-1:0] up;
    logic signed [VALUE_BITS-1:0] right;
    logic                         peak_calc;

    // Decided row sits in its parity's store, the row above in the other one
    assign centre = s1_ctl_reg.row_par ? buf1_a : buf0_a;
    assign up     = s1_ctl_reg.row_par ? buf0_a : buf1_a;
    assign right  = s1_ctl_reg.row_par ? buf1_b : buf0_b;

    assign peak_calc = (!s1_ctl_reg.has_down  || (centre >= s1_down_reg))
                    && (!s1_ctl_reg.has_up    || (centre >= up))
                    && (!s1_ctl_reg.has_left  || (centre >= left_reg))
                    && (!s1_ctl_reg.has_right || (centre >= right));

    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign take    = !s1_valid_reg || s1_move;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        s1_ctl_next    = s1_ctl_reg;
        s1_col_next    = s1_col_reg;
        s1_down_next   = s1_down_reg;
        left_next      = left_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        peak_next      = peak_reg;
        last_next      = last_reg;

        if (s1_move)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            row_next       = s1_ctl_reg.row;
            col_next       = s1_col_reg;
            peak_next      = peak_calc;
            last_next      = s1_ctl_reg.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Stage data only changes on a decision, so centre is always the previous one's
        if (enter)
        begin
            s1_valid_next = 1'b1;
            s1_ctl_next   = ctl;
            s1_col_next   = col;
            s1_down_next  = down;
            left_next     = centre;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg  <= s1_ctl_next;
        s1_col_reg  <= s1_col_next;
        s1_down_reg <= s1_down_next;
        left_reg    <= left_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        peak_reg    <= peak_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_row   = row_reg;
    assign cell_col   = col_reg;
    assign is_peak    = peak_reg;
    assign frame_last = last_reg;

endmodule

// ===== src/grid_local_maximum_finder.sv =====
// Top level of the four-neighbour grid local maximum finder.
// Usage:
//   cfg channel: cfg_index 0 sets the row count, 1 the column count; any such write
//   restarts the frame. cfg_ready is always high; write only while the block is idle.
//   in channel: command 0 carries one grid value in raster order, command 1 drains one
//   decision of the last row once the whole grid is in. Items that decide nothing
//   (extra pixels, early or surplus drains) are taken and dropped.
//   out channel: one beat per decided cell with its row, column, peak flag and a
//   frame-end flag on the final cell.
// Throughput is one item per cycle while out_ready is high. Accepting a deciding item
// reads the two line stores into the compare stage; the compare outcome is then
// registered in the result register. Holding out_ready low fills the compare stage and the result
// register, after which in_ready drops until a beat leaves.
// Reset clears the scan position and sets a 1 x 1 grid; the line stores are not
// cleared, as every entry read in a frame is written earlier in that frame.
module grid_local_maximum_finder #(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [glmf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [glmf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [VALUE_BITS-1:0]        pixel_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [glmf_pkg::ROW_BITS-1:0]       cell_row,
    output logic [$clog2(MAX_COLS)-1:0]         cell_col,
    output logic                                is_peak,
    output logic                                frame_last
);

    import glmf_pkg::*;

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam logic [COL_BITS-1:0] LAST_ADDR = COL_BITS'(MAX_COLS - 1);

    glmf_ctl_t                    ctl;
    logic [COL_BITS-1:0]          scan_col;
    logic [COL_BITS-1:0]          addr_b;
    logic                         accept;
    logic                         buf_wr_en;
    logic                         buf_wr_par;
    logic                         rd_en;
    logic signed [VALUE_BITS-1:0] buf0_a, buf0_b, buf1_a, buf1_b;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign rd_en     = accept && ctl.decide;
    assign addr_b    = (scan_col == LAST_ADDR) ? scan_col : (scan_col + COL_BITS'(1));

    glmf_scan #(
        .MAX_COLS (MAX_COLS),
        .COL_BITS (COL_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .command   (command),
        .ctl       (ctl),
        .col       (scan_col),
        .wr_en     (buf_wr_en),
        .wr_par    (buf_wr_par)
    );

    glmf_line_buf #(
        .DEPTH     (MAX_COLS),
        .ADDR_BITS (COL_BITS),
        .DATA_BITS (VALUE_BITS)
    ) u_buf0 (
        .clk       (clk),
        .wr_en     (buf_wr_en && !buf_wr_par),
        .wr_addr   (scan_col),
        .wr_data   (pixel_value),
        .rd_en     (rd_en),
        .rd_addr_a (scan_col),
        .rd_addr_b (addr_b),
        .rd_data_a (buf0_a),
        .rd_data_b (buf0_b)
    );

    glmf_line_buf #(
        .DEPTH     (MAX_COLS),
        .ADDR_BITS (COL_BITS),
        .DATA_BITS (VALUE_BITS)
    ) u_buf1 (
        .clk       (clk),
        .wr_en     (buf_wr_en && buf_wr_par),
        .wr_addr   (scan_col),
        .wr_data   (pixel_value),
        .rd_en     (rd_en),
        .rd_addr_a (scan_col),
        .rd_addr_b (addr_b),
        .rd_data_a (buf1_a),
        .rd_data_b (buf1_b)
    );

    glmf_peak #(
        .COL_BITS   (COL_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_peak (
        .clk        (clk),
        .rst_n      (rst_n),
        .enter      (rd_en),
        .ctl        (ctl),
        .col        (scan_col),
        .down       (pixel_value),
        .buf0_a     (buf0_a),
        .buf0_b     (buf0_b),
        .buf1_a     (buf1_a),
        .buf1_b     (buf1_b),
        .take       (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .is_peak    (is_peak),
        .frame_last (frame_last)
    );

`ifndef SYNTHESIS
    // A decision with no neighbour below only comes from a drain
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && !ctl.has_down) |-> (command == CMD_DRAIN))
        else $error("last-row decision taken on a pixel beat");

    // Line stores are only written by accepted pixel beats
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_wr_en |-> (accept && (command == CMD_PIXEL)))
        else $error("line store written without a pixel beat");

    // The frame-end cell sits in the last column
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.decide && ctl.last) |-> !ctl.has_right)
        else $error("frame end flagged before the last column");

    // Input only stalls while a result is held back by the receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled with no blocked result");
`endif

endmodule
